// ----- rtl/box_corner_hausdorff_distance_top_defines.svh -----
// ----------------------------------------------------------------------------
// box_corner_hausdorff_distance_top_defines
// assertion macros used by bchd_obuf
// ----------------------------------------------------------------------------
`ifndef BOX_CORNER_HAUSDORFF_DISTANCE_TOP_DEFINES_SVH
`define BOX_CORNER_HAUSDORFF_DISTANCE_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define BCHD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define BCHD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bchd_pkg.sv -----
// ----------------------------------------------------------------------------
// bchd_pkg
// shared constants for the rectangle distance pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bchd_pkg;

    // corners measured per rectangle
    localparam int CORNERS = 4;
    // two directions: corners of a against box b, corners of b against box a
    localparam int SIDES   = 2;

endpackage

// ----- rtl/bchd_geom.sv -----
// ----------------------------------------------------------------------------
// bchd_geom
// corner geometry: corner points, per-axis gaps, squares and squared distance
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bchd_geom #(
    parameter int COORD_BITS = 12
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        advance,
    input  logic                        in_valid,
    input  logic [COORD_BITS-1:0]       a_left,
    input  logic [COORD_BITS-1:0]       a_top,
    input  logic [COORD_BITS:0]         a_width,
    input  logic [COORD_BITS:0]         a_height,
    input  logic [COORD_BITS-1:0]       b_left,
    input  logic [COORD_BITS-1:0]       b_top,
    input  logic [COORD_BITS:0]         b_width,
    input  logic [COORD_BITS:0]         b_height,
    output logic                        out_valid,
    output logic [2*COORD_BITS+4:0]     sq [bchd_pkg::SIDES][bchd_pkg::CORNERS]
);
    import bchd_pkg::*;

    localparam int EW  = COORD_BITS + 2;
    localparam int PW  = 2 * EW;
    localparam int SQW = 2 * EW + 1;

    logic [COORD_BITS-1:0] org_x [SIDES];
    logic [COORD_BITS-1:0] org_y [SIDES];
    logic [COORD_BITS:0]   ext_w [SIDES];
    logic [COORD_BITS:0]   ext_h [SIDES];

    logic [EW-1:0]  px_reg [SIDES][CORNERS];
    logic [EW-1:0]  py_reg [SIDES][CORNERS];
    logic [EW-1:0]  bx_reg [SIDES];
    logic [EW-1:0]  by_reg [SIDES];
    logic [EW-1:0]  rx_reg [SIDES];
    logic [EW-1:0]  ry_reg [SIDES];
    logic [EW-1:0]  dx_reg [SIDES][CORNERS];
    logic [EW-1:0]  dy_reg [SIDES][CORNERS];
    logic [PW-1:0]  dx2_reg [SIDES][CORNERS];
    logic [PW-1:0]  dy2_reg [SIDES][CORNERS];
    logic [SQW-1:0] sq_reg [SIDES][CORNERS];
    logic [3:0]     valid_reg;

    always_comb begin
        org_x[0] = a_left;
        org_y[0] = a_top;
        ext_w[0] = a_width;
        ext_h[0] = a_height;
        org_x[1] = b_left;
        org_y[1] = b_top;
        ext_w[1] = b_width;
        ext_h[1] = b_height;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (advance) begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    // corner points and the far edges of the opposite box
    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int s = 0; s < SIDES; s++) begin
                bx_reg[s] <= EW'(org_x[SIDES-1-s]);
                by_reg[s] <= EW'(org_y[SIDES-1-s]);
                rx_reg[s] <= EW'(org_x[SIDES-1-s]) + EW'(ext_w[SIDES-1-s]);
                ry_reg[s] <= EW'(org_y[SIDES-1-s]) + EW'(ext_h[SIDES-1-s]);
                for (int c = 0; c < CORNERS; c++) begin
                    px_reg[s][c] <= EW'(org_x[s]) + ((c >= 2) ? EW'(ext_w[s]) : EW'(0));
                    py_reg[s][c] <= EW'(org_y[s]) +
                                    ((c == 1 || c == 3) ? EW'(ext_h[s]) : EW'(0));
                end
            end
        end
    end

    // per-axis gap, zero when the coordinate lies within the box span
    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int s = 0; s < SIDES; s++) begin
                for (int c = 0; c < CORNERS; c++) begin
                    if (px_reg[s][c] < bx_reg[s]) begin
                        dx_reg[s][c] <= bx_reg[s] - px_reg[s][c];
                    end else if (px_reg[s][c] >= rx_reg[s]) begin
                        dx_reg[s][c] <= px_reg[s][c] - rx_reg[s];
                    end else begin
                        dx_reg[s][c] <= '0;
                    end
                    if (py_reg[s][c] < by_reg[s]) begin
                        dy_reg[s][c] <= by_reg[s] - py_reg[s][c];
                    end else if (py_reg[s][c] >= ry_reg[s]) begin
                        dy_reg[s][c] <= py_reg[s][c] - ry_reg[s];
                    end else begin
                        dy_reg[s][c] <= '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int s = 0; s < SIDES; s++) begin
                for (int c = 0; c < CORNERS; c++) begin
                    dx2_reg[s][c] <= PW'(dx_reg[s][c]) * PW'(dx_reg[s][c]);
                    dy2_reg[s][c] <= PW'(dy_reg[s][c]) * PW'(dy_reg[s][c]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int s = 0; s < SIDES; s++) begin
                for (int c = 0; c < CORNERS; c++) begin
                    sq_reg[s][c] <= SQW'(dx2_reg[s][c]) + SQW'(dy2_reg[s][c]);
                end
            end
        end
    end

    assign sq        = sq_reg;
    assign out_valid = valid_reg[3];

endmodule

// ----- rtl/bchd_select.sv -----
// ----------------------------------------------------------------------------
// bchd_select
// minimum over corners per direction, then the larger of the two minima
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bchd_select #(
    parameter int SQ_BITS = 29
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  logic                in_valid,
    input  logic [SQ_BITS-1:0]  sq [bchd_pkg::SIDES][bchd_pkg::CORNERS],
    output logic                out_valid,
    output logic [SQ_BITS-1:0]  worst
);
    import bchd_pkg::*;

    localparam int HALF = CORNERS / 2;

    logic [SQ_BITS-1:0] pair_reg [SIDES][HALF];
    logic [SQ_BITS-1:0] side_reg [SIDES];
    logic [SQ_BITS-1:0] worst_reg;
    logic [2:0]         valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (advance) begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    // squared lengths order the same way as the rounded roots
    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int s = 0; s < SIDES; s++) begin
                for (int p = 0; p < HALF; p++) begin
                    pair_reg[s][p] <= (sq[s][2*p+1] < sq[s][2*p]) ? sq[s][2*p+1] : sq[s][2*p];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int s = 0; s < SIDES; s++) begin
                side_reg[s] <= (pair_reg[s][1] < pair_reg[s][0]) ? pair_reg[s][1]
                                                                  : pair_reg[s][0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            worst_reg <= (side_reg[1] > side_reg[0]) ? side_reg[1] : side_reg[0];
        end
    end

    assign worst     = worst_reg;
    assign out_valid = valid_reg[2];

endmodule

// ----- rtl/bchd_sqrt.sv -----
// ----------------------------------------------------------------------------
// bchd_sqrt
// pipelined digit-by-digit square root, one result bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bchd_sqrt #(
    parameter int IN_BITS   = 29,
    parameter int FRAC_BITS = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 advance,
    input  logic                                 in_valid,
    input  logic [IN_BITS-1:0]                   sq_in,
    output logic                                 out_valid,
    output logic [(IN_BITS+2*FRAC_BITS+1)/2-1:0] root
);
    localparam int RB    = (IN_BITS + 2 * FRAC_BITS + 1) / 2;
    localparam int RAD_W = 2 * RB;
    localparam int RW    = RB + 3;

    logic [RW-1:0]    rem_reg  [RB-1];
    logic [RAD_W-1:0] rad_reg  [RB-1];
    logic [RB-1:0]    root_reg [RB];
    logic [RB-1:0]    valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (advance) begin
            valid_reg <= {valid_reg[RB-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < RB; k++) begin : g_step
        logic [RW-1:0]    rem_in;
        logic [RW-1:0]    rem_sh;
        logic [RW-1:0]    trial;
        logic [RB-1:0]    root_in;
        logic [RAD_W-1:0] rad_in;
        logic [RW:0]      diff;
        logic             take;

        if (k == 0) begin : g_head
            // fraction bits come in as zero digit pairs below the integer part
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = RAD_W'(sq_in) << (2 * FRAC_BITS);
        end else begin : g_tail
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
        end

        assign rem_sh = {rem_in[RW-3:0], rad_in[RAD_W-1 -: 2]};
        assign trial  = RW'({root_in, 2'b01});
        assign diff   = {1'b0, rem_sh} - {1'b0, trial};
        assign take   = !diff[RW];

        always_ff @(posedge aclk) begin
            if (advance) begin
                root_reg[k] <= {root_in[RB-2:0], take};
            end
        end

        if (k < RB - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (advance) begin
                    rem_reg[k] <= take ? diff[RW-1:0] : rem_sh;
                    rad_reg[k] <= rad_in << 2;
                end
            end
        end
    end

    assign root      = root_reg[RB-1];
    assign out_valid = valid_reg[RB-1];

endmodule

// ----- rtl/bchd_obuf.sv -----
// ----------------------------------------------------------------------------
// bchd_obuf
// output register with a skid slot; freezes the pipeline only when both fill
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "box_corner_hausdorff_distance_top_defines.svh"

module bchd_obuf #(
    parameter int OUT_BITS = 22
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                pipe_valid,
    input  logic [OUT_BITS-1:0] pipe_data,
    output logic                advance,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [OUT_BITS-1:0] m_distance
);
    logic                m_valid_reg;
    logic                m_valid_next;
    logic [OUT_BITS-1:0] data_reg;
    logic [OUT_BITS-1:0] data_next;
    logic                skid_valid_reg;
    logic                skid_valid_next;
    logic [OUT_BITS-1:0] skid_data_reg;
    logic [OUT_BITS-1:0] skid_data_next;
    logic                out_free;

    assign advance  = !skid_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next    = m_valid_reg;
        data_next       = data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free) begin
            if (skid_valid_reg) begin
                m_valid_next    = 1'b1;
                data_next       = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                m_valid_next = pipe_valid;
                data_next    = pipe_data;
            end
        end else if (advance && pipe_valid) begin
            // beat leaving the pipeline while the output is stalled
            skid_valid_next = 1'b1;
            skid_data_next  = pipe_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg      <= data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_distance = data_reg;

    `BCHD_ASSERT_NOW(a_skid_behind_out, aclk, aresetn, skid_valid_reg, m_valid_reg, "skid beat with empty output")
    `BCHD_ASSERT_NEXT(a_stall_to_skid, aclk, aresetn, pipe_valid && advance && m_valid_reg && !m_ready, skid_valid_reg, "stalled beat not kept in skid")
    `BCHD_ASSERT_NEXT(a_skid_drains, aclk, aresetn, skid_valid_reg && m_ready, m_valid_reg && !skid_valid_reg, "skid beat not moved to output")

endmodule

// ----- rtl/box_corner_hausdorff_distance_top.sv -----
// ----------------------------------------------------------------------------
// box_corner_hausdorff_distance_top
// approximate Hausdorff distance between two axis-aligned rectangles
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one beat holds both rectangles (left, top, width, height).
//   m_ channel: one beat per input beat, m_distance in unsigned fixed point
//   with FRAC_BITS fraction bits, square root rounded down.
//   Both channels are valid/ready; a beat moves when valid and ready are high.
// Pipeline: 4 geometry stages, 3 min/max stages, COORD_BITS+FRAC_BITS+3 root
//   stages (one root bit each) and the output register; the first stage loads
//   at the accepting edge.
// Throughput: one beat per cycle while no beat waits in the skid slot, set by
//   the fully pipelined root unit.
// Stall: a beat that leaves the pipeline while the output is held goes to a
//   one-entry skid slot; only then does s_ready drop and the whole pipeline
//   freeze until the output is taken. No beat is lost or repeated.
// Reset: aresetn low at a clock edge clears all valid bits; s_ready is high
//   in the first cycle after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module box_corner_hausdorff_distance_top #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [COORD_BITS-1:0]           s_a_left,
    input  logic [COORD_BITS-1:0]           s_a_top,
    input  logic [COORD_BITS:0]             s_a_width,
    input  logic [COORD_BITS:0]             s_a_height,
    input  logic [COORD_BITS-1:0]           s_b_left,
    input  logic [COORD_BITS-1:0]           s_b_top,
    input  logic [COORD_BITS:0]             s_b_width,
    input  logic [COORD_BITS:0]             s_b_height,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [COORD_BITS+FRAC_BITS+1:0] m_distance
);
    import bchd_pkg::*;

    localparam int SQ_BITS   = 2 * (COORD_BITS + 2) + 1;
    localparam int ROOT_BITS = (SQ_BITS + 2 * FRAC_BITS + 1) / 2;
    localparam int OUT_BITS  = COORD_BITS + FRAC_BITS + 2;

    logic                 advance;
    logic                 geom_valid;
    logic [SQ_BITS-1:0]   geom_sq [SIDES][CORNERS];
    logic                 sel_valid;
    logic [SQ_BITS-1:0]   sel_worst;
    logic                 root_valid;
    logic [ROOT_BITS-1:0] root_data;

    assign s_ready = advance;

    bchd_geom #(
        .COORD_BITS (COORD_BITS)
    ) u_geom (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (s_valid),
        .a_left    (s_a_left),
        .a_top     (s_a_top),
        .a_width   (s_a_width),
        .a_height  (s_a_height),
        .b_left    (s_b_left),
        .b_top     (s_b_top),
        .b_width   (s_b_width),
        .b_height  (s_b_height),
        .out_valid (geom_valid),
        .sq        (geom_sq)
    );

    bchd_select #(
        .SQ_BITS (SQ_BITS)
    ) u_select (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (geom_valid),
        .sq        (geom_sq),
        .out_valid (sel_valid),
        .worst     (sel_worst)
    );

    bchd_sqrt #(
        .IN_BITS   (SQ_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (sel_valid),
        .sq_in     (sel_worst),
        .out_valid (root_valid),
        .root      (root_data)
    );

    bchd_obuf #(
        .OUT_BITS (OUT_BITS)
    ) u_obuf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pipe_valid (root_valid),
        .pipe_data  (root_data[OUT_BITS-1:0]),
        .advance    (advance),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_distance (m_distance)
    );

endmodule

// ----- tb/box_corner_hausdorff_distance_top_tb.sv -----
// ----------------------------------------------------------------------------
// box_corner_hausdorff_distance_top_tb
// self-checking bench for the rectangle corner distance pipeline: rectangle
// pairs are sent over the s_ channel, each m_ beat is checked against an
// in-bench computation of the corner distances and the square root
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module box_corner_hausdorff_distance_top_tb;

    import bchd_pkg::*;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 8;
    localparam int DIST_BITS  = COORD_BITS + FRAC_BITS + 2;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [COORD_BITS-1:0] a_left;
        logic [COORD_BITS-1:0] a_top;
        logic [COORD_BITS:0]   a_width;
        logic [COORD_BITS:0]   a_height;
        logic [COORD_BITS-1:0] b_left;
        logic [COORD_BITS-1:0] b_top;
        logic [COORD_BITS:0]   b_width;
        logic [COORD_BITS:0]   b_height;
    } rect_pair_t;

    localparam int PAIR_BITS = $bits(rect_pair_t);

    logic                  aclk       = 1'b0;
    logic                  aresetn    = 1'b0;
    logic                  s_valid    = 1'b0;
    logic                  s_ready;
    logic [COORD_BITS-1:0] s_a_left   = '0;
    logic [COORD_BITS-1:0] s_a_top    = '0;
    logic [COORD_BITS:0]   s_a_width  = '0;
    logic [COORD_BITS:0]   s_a_height = '0;
    logic [COORD_BITS-1:0] s_b_left   = '0;
    logic [COORD_BITS-1:0] s_b_top    = '0;
    logic [COORD_BITS:0]   s_b_width  = '0;
    logic [COORD_BITS:0]   s_b_height = '0;
    logic                  m_valid;
    logic                  m_ready    = 1'b0;
    logic [DIST_BITS-1:0]  m_distance;

    logic [DIST_BITS-1:0] pending_distances[$];
    logic [DIST_BITS-1:0] want_distance;
    int  mismatch_count = 0;
    int  cycle_count    = 0;
    bit  tx_idle_on     = 1'b1;
    bit  rx_idle_on     = 1'b1;
    logic rx_holding    = 1'b0;
    event hold_go;

    box_corner_hausdorff_distance_top #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_a_left  (s_a_left),
        .s_a_top   (s_a_top),
        .s_a_width (s_a_width),
        .s_a_height(s_a_height),
        .s_b_left  (s_b_left),
        .s_b_top   (s_b_top),
        .s_b_width (s_b_width),
        .s_b_height(s_b_height),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_distance(m_distance)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // distance computation
    // ------------------------------------------------------------------

    // floor(sqrt(v) * 2^FRAC_BITS), built one result bit at a time
    function automatic longint unsigned fixed_root(longint unsigned v);
        longint unsigned radicand;
        longint unsigned root;
        longint unsigned trial;
        radicand = v << (2 * FRAC_BITS);
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= radicand) root = trial;
        end
        return root;
    endfunction

    function automatic longint unsigned corner_gap(longint unsigned px, longint unsigned py,
                                                   longint unsigned bx, longint unsigned by,
                                                   longint unsigned bw, longint unsigned bh);
        longint unsigned rx;
        longint unsigned ry;
        rx = bx + bw;
        ry = by + bh;
        if (px >= bx && px < rx && py >= by && py < ry) return 0;
        if (px < bx) begin
            if (py < by) return fixed_root((bx - px) * (bx - px) + (by - py) * (by - py));
            if (py < ry) return (bx - px) << FRAC_BITS;
            return fixed_root((bx - px) * (bx - px) + (py - ry) * (py - ry));
        end
        if (px < rx) begin
            if (py < by) return (by - py) << FRAC_BITS;
            // a corner sitting exactly on the far edge inside the column counts as inside
            if (py > ry) return (py - ry) << FRAC_BITS;
            return 0;
        end
        if (py < by) return fixed_root((px - rx) * (px - rx) + (by - py) * (by - py));
        if (py < ry) return (px - rx) << FRAC_BITS;
        return fixed_root((px - rx) * (px - rx) + (py - ry) * (py - ry));
    endfunction

    function automatic longint unsigned nearest_corner_gap(
        longint unsigned x, longint unsigned y, longint unsigned w, longint unsigned h,
        longint unsigned bx, longint unsigned by, longint unsigned bw, longint unsigned bh);
        longint unsigned best;
        longint unsigned gap;
        best = '1;
        for (int k = 0; k < CORNERS; k++) begin
            gap = corner_gap(x + (k[1] ? w : 0), y + (k[0] ? h : 0), bx, by, bw, bh);
            if (gap < best) best = gap;
        end
        return best;
    endfunction

    function automatic logic [DIST_BITS-1:0] hausdorff_estimate(rect_pair_t p);
        longint unsigned a_to_b;
        longint unsigned b_to_a;
        a_to_b = nearest_corner_gap(p.a_left, p.a_top, p.a_width, p.a_height,
                                    p.b_left, p.b_top, p.b_width, p.b_height);
        b_to_a = nearest_corner_gap(p.b_left, p.b_top, p.b_width, p.b_height,
                                    p.a_left, p.a_top, p.a_width, p.a_height);
        return DIST_BITS'(a_to_b > b_to_a ? a_to_b : b_to_a);
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic rect_pair_t make_pair(int unsigned ax, int unsigned ay,
                                             int unsigned aw, int unsigned ah,
                                             int unsigned bx, int unsigned by,
                                             int unsigned bw, int unsigned bh);
        rect_pair_t p;
        p.a_left   = COORD_BITS'(ax);
        p.a_top    = COORD_BITS'(ay);
        p.a_width  = (COORD_BITS+1)'(aw);
        p.a_height = (COORD_BITS+1)'(ah);
        p.b_left   = COORD_BITS'(bx);
        p.b_top    = COORD_BITS'(by);
        p.b_width  = (COORD_BITS+1)'(bw);
        p.b_height = (COORD_BITS+1)'(bh);
        return p;
    endfunction

    // mostly nearby small boxes so every region around a box is reached
    function automatic rect_pair_t random_pair();
        rect_pair_t p;
        int unsigned pick;
        int unsigned base_x;
        int unsigned base_y;
        pick = $urandom_range(99);
        base_x = $urandom_range(4000);
        base_y = $urandom_range(4000);
        if (pick < 25) begin
            p = rect_pair_t'(PAIR_BITS'({$urandom, $urandom, $urandom, $urandom}));
        end else if (pick < 35) begin
            p = make_pair($urandom_range(4095), $urandom_range(4095),
                          $urandom_range(8191, 3000), $urandom_range(8191, 3000),
                          $urandom_range(4095), $urandom_range(4095),
                          $urandom_range(8191), $urandom_range(8191));
        end else if (pick < 50) begin
            // boxes touching along an edge or at a corner
            p = make_pair(base_x, base_y, $urandom_range(40), $urandom_range(40),
                          0, 0, $urandom_range(40), $urandom_range(40));
            p.b_left = COORD_BITS'(p.a_left + p.a_width - ($urandom_range(2)));
            p.b_top  = COORD_BITS'(p.a_top + p.a_height - ($urandom_range(2)));
        end else begin
            p = make_pair(base_x + $urandom_range(40), base_y + $urandom_range(40),
                          $urandom_range(40), $urandom_range(40),
                          base_x + $urandom_range(40), base_y + $urandom_range(40),
                          $urandom_range(40), $urandom_range(40));
        end
        return p;
    endfunction

    task automatic send_pair(rect_pair_t p);
        while (tx_idle_on && $urandom_range(99) < 36) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_a_left   <= p.a_left;
        s_a_top    <= p.a_top;
        s_a_width  <= p.a_width;
        s_a_height <= p.a_height;
        s_b_left   <= p.b_left;
        s_b_top    <= p.b_top;
        s_b_width  <= p.b_width;
        s_b_height <= p.b_height;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_distances.insert(pending_distances.size(), hausdorff_estimate(p));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    task automatic test_field_extremes();
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(make_pair(4095, 4095, 8191, 8191, 4095, 4095, 8191, 8191));
        send_pair(make_pair(0, 0, 0, 0, 4095, 4095, 8191, 8191));
        send_pair(make_pair(4095, 4095, 8191, 8191, 0, 0, 0, 0));
        send_pair(make_pair(4095, 0, 0, 8191, 0, 4095, 8191, 0));
        send_pair(make_pair(0, 4095, 4096, 4096, 4095, 0, 4096, 4096));
    endtask

    task automatic test_box_geometry();
        // identical boxes
        send_pair(make_pair(100, 200, 30, 40, 100, 200, 30, 40));
        // empty boxes, zero width and zero height
        send_pair(make_pair(100, 100, 0, 20, 90, 90, 40, 40));
        send_pair(make_pair(100, 100, 20, 0, 90, 90, 40, 40));
        // disjoint on the diagonal
        send_pair(make_pair(0, 0, 10, 10, 100, 200, 5, 5));
        // separated along one axis only
        send_pair(make_pair(50, 10, 40, 10, 60, 80, 10, 10));
        send_pair(make_pair(10, 50, 10, 40, 80, 60, 10, 10));
        // corner on the far bottom edge inside the column
        send_pair(make_pair(10, 10, 20, 20, 15, 30, 5, 5));
        // corner on the far right edge is outside the half-open box
        send_pair(make_pair(10, 10, 20, 20, 30, 15, 5, 5));
        // nested box
        send_pair(make_pair(0, 0, 500, 500, 200, 200, 10, 10));
        // corners exactly touching
        send_pair(make_pair(10, 10, 10, 10, 20, 20, 10, 10));
    endtask

    task automatic test_random_pairs(int count);
        for (int i = 0; i < count; i++) send_pair(random_pair());
    endtask

    task automatic test_no_idle_stretch(int count);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_random_pairs(count);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // receiver holds off while the sender keeps offering beats until s_ready drops
    task automatic test_output_backpressure(int count);
        tx_idle_on = 1'b0;
        -> hold_go;
        test_random_pairs(count);
        tx_idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // receiver, checker and watchdog
    // ------------------------------------------------------------------

    initial begin
        forever begin
            @(hold_go);
            rx_holding <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge aclk);
            rx_holding <= 1'b0;
        end
    end

    always @(posedge aclk) begin
        if (rx_holding) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !(rx_idle_on && $urandom_range(99) < 36);
        end
    end

    task automatic note_mismatch(string what, logic [DIST_BITS-1:0] want,
                                 logic [DIST_BITS-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch at %0t: %s expected %0d actual %0d", $realtime, what, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_distances.size() == 0) begin
                note_mismatch("unexpected beat, distance", '0, m_distance);
            end else begin
                want_distance = pending_distances.pop_front();
                if (m_distance !== want_distance) begin
                    note_mismatch("distance", want_distance, m_distance);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_field_extremes();
        test_box_geometry();
        test_random_pairs(200);
        test_no_idle_stretch(120);
        test_output_backpressure(100);
        test_random_pairs(120);
        s_valid <= 1'b0;

        while (pending_distances.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && pending_distances.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/bchd_pkg.sv
rtl/bchd_geom.sv
rtl/bchd_select.sv
rtl/bchd_sqrt.sv
rtl/bchd_obuf.sv
rtl/box_corner_hausdorff_distance_top.sv
tb/box_corner_hausdorff_distance_top_tb.sv
